// ===== src/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the binary to decimal ASCII block
// Holds field widths, the BCD cell count and the control bundle for the cells.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [DIGIT_W-1:0] t_digit;

    // One command for the whole row of cells per cycle
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction and shift in one bit
        logic move;    // take the digit from the lower neighbor
    } t_cell_ctrl;

endpackage

// ===== src/bdc_cell.sv =====
// ----------------------------------------------------------------------------
// bdc_cell: one BCD digit of the double-dabble row
// Corrects and shifts one bit per cycle during conversion, then passes whole
// digits upward so the row can be read out from its top cell.
// ----------------------------------------------------------------------------
module bdc_cell (
    input  logic               i_clk,
    input  bdc_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_bit,
    input  bdc_pkg::t_digit    i_digit,
    output logic               o_bit,
    output bdc_pkg::t_digit    o_digit
);
    import bdc_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit w_adj;

    // Add 3 when the digit would overflow past 9 after doubling
    assign w_adj   = (r_digit >= DIGIT_W'(5)) ? (r_digit + DIGIT_W'(3)) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 64-bit value to decimal ASCII digits
//
// Input channel (i_valid/o_ready, i_value) takes one 64-bit number per
// transfer. Output channel (o_valid/i_ready) gives one character per
// transfer on o_digit_char, most significant digit first, no leading zeros;
// o_last_digit marks the final character. Zero gives a single '0'.
// A row of 20 BCD cells runs double dabble, one input bit per cycle. Leading
// zero digits are then dropped at one per cycle (up to 19 of them), readout
// then starts, and the digits leave at one per cycle while the receiver keeps
// i_ready high. The next item is accepted as soon as the last character is in
// the output register.
// A stalled receiver holds the output register and the row of cells.
// Reset (synchronous, active low) returns the block to idle and drops any
// pending character; the cells need no reset since each item clears them.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bdc_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bdc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                          o_last_digit
);
    import bdc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [VALUE_W-1:0]   r_value;
    logic [VALUE_W-1:0]   n_value;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [BIT_CNT_W-1:0] n_bit_cnt;
    logic [LEFT_W-1:0]    r_left;
    logic [LEFT_W-1:0]    n_left;
    logic                 r_o_valid;
    logic                 n_o_valid;
    logic [CHAR_W-1:0]    r_char;
    logic [CHAR_W-1:0]    n_char;
    logic                 r_last;
    logic                 n_last;

    t_cell_ctrl           w_ctrl;
    logic                 w_bits   [NUM_DIGITS+1];
    t_digit               w_digits [NUM_DIGITS+1];
    t_digit               w_top;
    logic                 w_load;

    assign w_bits[0]   = r_value[VALUE_W-1];
    assign w_digits[0] = '0;
    assign w_top       = w_digits[NUM_DIGITS];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            bdc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_bits[g]),
                .i_digit (w_digits[g]),
                .o_bit   (w_bits[g+1]),
                .o_digit (w_digits[g+1])
            );
        end
    endgenerate

    assign w_load = (r_state == S_EMIT) && (!r_o_valid || i_ready);

    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_bit_cnt    = r_bit_cnt;
        n_left       = r_left;
        n_char       = r_char;
        n_last       = r_last;
        n_o_valid    = r_o_valid && !i_ready;
        w_ctrl       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_ctrl.clear = 1'b1;
                    n_value      = i_value;
                    n_bit_cnt    = BIT_CNT_W'(VALUE_W - 1);
                    n_state      = S_CONV;
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_value       = {r_value[VALUE_W-2:0], 1'b0};
                n_bit_cnt     = r_bit_cnt - BIT_CNT_W'(1);
                if (r_bit_cnt == '0) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if ((w_top == '0) && (r_left > LEFT_W'(1))) begin
                    w_ctrl.move = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    w_ctrl.move = 1'b1;
                    n_char      = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, w_top};
                    n_last      = (r_left == LEFT_W'(1));
                    n_o_valid   = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_value   <= n_value;
        r_bit_cnt <= n_bit_cnt;
        r_left    <= n_left;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for binary_to_decimal_ascii
// Sends 64-bit values over the input channel and checks every character on
// the output channel, in order, against decimal digits worked out here.
// Both sides idle and stall at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    localparam int RADIX          = 10;
    localparam int MAX_WAIT       = 18;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 120;

    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_char_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [CHAR_W-1:0]  o_digit_char;
    logic               o_last_digit;

    t_char_item expected_digits[$];
    int         error_count = 0;
    int         quiet_cycles = 0;
    bit         src_gaps_on = 1'b1;
    bit         snk_stalls_on = 1'b1;

    binary_to_decimal_ascii dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Append the decimal text of one value, most significant digit first
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] lsd_first [NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 count;
        t_char_item         item;
        rest  = value;
        count = 0;
        do begin
            lsd_first[count] = DIGIT_W'(rest % RADIX);
            rest             = rest / RADIX;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            item.digit_char = ASCII_ZERO + CHAR_W'(lsd_first[k]);
            item.last_digit = (k == 0);
            expected_digits.push_back(item);
        end
    endfunction

    // Random value: full width or cut to a random bit length
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] raw;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(0, 2) == 0)
            return raw;
        return raw >> $urandom_range(0, VALUE_W - 1);
    endfunction

    // Predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                queue_decimal_digits(i_value);
            if (o_valid && i_ready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected character %0d (last %0b)", o_digit_char, o_last_digit);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (o_digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, o_digit_char);
                        error_count++;
                    end
                    if (o_last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0b, got %0b",
                               want.last_digit, o_last_digit);
                        error_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stall a random number of cycles before each character
    initial begin : sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = snk_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold until every pending character has come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_digits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_values();
        logic [VALUE_W-1:0] values [$];
        values = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
            64'hFFFF_FFFF_FFFF_FFFF,            // largest, 20 digits
            64'd10000000000000000000,           // smallest 20-digit value
            64'd9999999999999999999,            // largest 19-digit value
            64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'd12345678901234567890, 64'h0000_0001_0000_0000,
            64'h0000_0000_FFFF_FFFF, 64'd1000000000, 64'd999999999,
            64'd0, 64'd7
        };
        foreach (values[n])
            send_value(values[n]);
    endtask

    task automatic test_random_values();
        for (int seg = 0; seg < 8; seg++) begin
            src_gaps_on   = ($urandom_range(0, 3) != 0);
            snk_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (30) send_value(draw_value());
        end
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        src_gaps_on   = 1'b0;
        snk_stalls_on = 1'b0;
        repeat (30) begin
            case ($urandom_range(0, 3))
                0: send_value('0);
                1: send_value('1);
                default: send_value(draw_value());
            endcase
        end
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat ($urandom_range(1, 5)) send_value(draw_value());
            hold_until_drained();
        end
    endtask

    initial begin : main
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_values();
        test_drain_pause();
        test_random_values();
        test_back_to_back();
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
